>>> hdl/dmpf_pkg.sv
`default_nettype none

package dmpf_pkg;

    localparam int DEF_MAX_WIDTH = 128;
    localparam int DEF_MAX_PAGES = 8;

    localparam int X_W        = 7;
    localparam int Y_W        = 6;
    localparam int PIX_ADDR_W = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic REG_PAGE_STRIDE  = 1'b0;
    localparam logic REG_TILE_PATTERN = 1'b1;

    localparam logic [7:0] PAGE_STRIDE_RESET  = 8'd128;
    localparam logic [3:0] TILE_PATTERN_RESET = 4'd0;

    localparam logic [31:0] WEIGHT_R = 32'd19749;
    localparam logic [31:0] WEIGHT_G = 32'd38771;
    localparam logic [31:0] WEIGHT_B = 32'd7530;

    localparam logic [X_W-1:0] EMPTY_LEFT   = 7'd127;
    localparam logic [X_W-1:0] EMPTY_RIGHT  = 7'd0;
    localparam logic [Y_W-1:0] EMPTY_TOP    = 6'd63;
    localparam logic [Y_W-1:0] EMPTY_BOTTOM = 6'd0;

    typedef struct packed {
        logic [1:0]            op;
        logic                  in_range;
        logic [PIX_ADDR_W-1:0] addr;
        logic [2:0]            bit_sel;
        logic                  pix_on;
        logic [X_W-1:0]        x;
        logic [Y_W-1:0]        y;
    } cmd_t;

    typedef struct packed {
        logic [3:0]     pad;
        logic [Y_W-1:0] bottom;
        logic [Y_W-1:0] top;
        logic [X_W-1:0] right;
        logic [X_W-1:0] left;
        logic           rect_valid;
        logic           pixel_on;
    } result_t;

    function automatic logic [7:0] bayer(input logic [3:0] idx);
        logic [7:0] val;
        begin
            unique case (idx)
                4'd0:  val = 8'd8;
                4'd1:  val = 8'd136;
                4'd2:  val = 8'd40;
                4'd3:  val = 8'd168;
                4'd4:  val = 8'd200;
                4'd5:  val = 8'd72;
                4'd6:  val = 8'd232;
                4'd7:  val = 8'd104;
                4'd8:  val = 8'd56;
                4'd9:  val = 8'd184;
                4'd10: val = 8'd24;
                4'd11: val = 8'd152;
                4'd12: val = 8'd248;
                4'd13: val = 8'd120;
                4'd14: val = 8'd216;
                4'd15: val = 8'd88;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/dmpf_ram.sv
`default_nettype none

module dmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/dmpf_fifo.sv
`default_nettype none

module dmpf_fifo
    import dmpf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dmpf_front.sv
`default_nettype none

module dmpf_front
    import dmpf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        hold,
    input  wire logic [7:0]  page_stride,
    input  wire logic [3:0]  tile_pattern,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             push,
    output cmd_t             push_data,
    input  wire logic        full
);

    localparam int STORE_BYTES = MAX_WIDTH * MAX_PAGES;

    logic                  accept;
    logic                  s1_adv;
    logic                  s2_ready;
    logic [3:0]            offset;
    logic [1:0]            col_sel;
    logic [1:0]            row_sel;
    logic [31:0]           weighted_sum;
    logic [8:0]            level;
    logic [PIX_ADDR_W-1:0] addr_calc;

    logic                  s1_valid_reg, s1_valid_next;
    logic [1:0]            s1_op_reg;
    logic [X_W-1:0]        s1_x_reg;
    logic [Y_W-1:0]        s1_y_reg;
    logic [15:0]           s1_rsq_reg;
    logic [15:0]           s1_gsq_reg;
    logic [15:0]           s1_bsq_reg;

    logic                  s2_valid_reg, s2_valid_next;
    logic [1:0]            s2_op_reg;
    logic [X_W-1:0]        s2_x_reg;
    logic [Y_W-1:0]        s2_y_reg;
    logic [PIX_ADDR_W-1:0] s2_addr_reg;
    logic                  s2_in_range_reg;
    logic [31:0]           s2_rw_reg;
    logic [31:0]           s2_gw_reg;
    logic [31:0]           s2_bw_reg;
    logic [7:0]            s2_thresh_reg;

    assign s2_ready = !s2_valid_reg || !full;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_tready = !hold && (!s1_valid_reg || s2_ready);
    assign accept   = s_tvalid && s_tready;
    assign push     = s2_valid_reg && !full;

    assign offset    = 4'(bayer(tile_pattern) >> 4);
    assign col_sel   = s1_x_reg[1:0] + offset[1:0];
    assign row_sel   = s1_y_reg[1:0] + offset[3:2];
    assign addr_calc = PIX_ADDR_W'(s1_x_reg)
                     + PIX_ADDR_W'(s1_y_reg[5:3]) * PIX_ADDR_W'(page_stride);

    assign weighted_sum = s2_rw_reg + s2_gw_reg + s2_bw_reg;
    assign level        = {1'b0, weighted_sum[31:24]} + {1'b0, s2_thresh_reg};

    always_comb
    begin
        push_data          = '0;
        push_data.op       = s2_op_reg;
        push_data.in_range = s2_in_range_reg;
        push_data.addr     = s2_addr_reg;
        push_data.bit_sel  = s2_y_reg[2:0];
        push_data.pix_on   = level[8];
        push_data.x        = s2_x_reg;
        push_data.y        = s2_y_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = (s_tuser != OP_NONE);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (push)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= s_tuser;
            s1_x_reg   <= s_tdata[6:0];
            s1_y_reg   <= s_tdata[12:7];
            s1_rsq_reg <= 16'(s_tdata[20:13]) * 16'(s_tdata[20:13]);
            s1_gsq_reg <= 16'(s_tdata[28:21]) * 16'(s_tdata[28:21]);
            s1_bsq_reg <= 16'(s_tdata[36:29]) * 16'(s_tdata[36:29]);
        end
        if (s1_adv)
        begin
            s2_op_reg       <= s1_op_reg;
            s2_x_reg        <= s1_x_reg;
            s2_y_reg        <= s1_y_reg;
            s2_addr_reg     <= addr_calc;
            s2_in_range_reg <= (32'(addr_calc) < 32'(STORE_BYTES));
            s2_rw_reg       <= 32'(s1_rsq_reg) * WEIGHT_R;
            s2_gw_reg       <= 32'(s1_gsq_reg) * WEIGHT_G;
            s2_bw_reg       <= 32'(s1_bsq_reg) * WEIGHT_B;
            s2_thresh_reg   <= bayer({row_sel, col_sel});
        end
    end

endmodule

`default_nettype wire

>>> hdl/dmpf_back.sv
`default_nettype none

module dmpf_back
    import dmpf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        head,
    input  wire logic        empty,
    output logic             pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    localparam int STORE_BYTES = MAX_WIDTH * MAX_PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    cmd_t           cmd_reg, cmd_next;

    logic           dirty_valid_reg, dirty_valid_next;
    logic [X_W-1:0] dirty_left_reg, dirty_left_next;
    logic [X_W-1:0] dirty_right_reg, dirty_right_next;
    logic [Y_W-1:0] dirty_top_reg, dirty_top_next;
    logic [Y_W-1:0] dirty_bottom_reg, dirty_bottom_next;

    logic           out_valid_reg, out_valid_next;
    result_t        out_data_reg, out_data_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [7:0]     wdata;
    logic [AW-1:0]  raddr;
    logic [7:0]     rdata;
    logic [7:0]     mask;
    logic           out_free;
    logic           load_res;
    result_t        res;

    dmpf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign mask     = 8'b1 << cmd_reg.bit_sel;
    assign raddr    = AW'(head.addr);

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        cmd_next          = cmd_reg;
        dirty_valid_next  = dirty_valid_reg;
        dirty_left_next   = dirty_left_reg;
        dirty_right_next  = dirty_right_reg;
        dirty_top_next    = dirty_top_reg;
        dirty_bottom_next = dirty_bottom_reg;
        pop               = 1'b0;
        we                = 1'b0;
        waddr             = AW'(cmd_reg.addr);
        wdata             = 8'h00;
        load_res          = 1'b0;
        res               = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.op)
                        OP_DRAW:
                        begin
                            pop              = 1'b1;
                            cmd_next         = head;
                            dirty_valid_next = 1'b1;
                            if (head.x < dirty_left_reg)
                            begin
                                dirty_left_next = head.x;
                            end
                            if (head.x > dirty_right_reg)
                            begin
                                dirty_right_next = head.x;
                            end
                            if (head.y < dirty_top_reg)
                            begin
                                dirty_top_next = head.y;
                            end
                            if (head.y > dirty_bottom_reg)
                            begin
                                dirty_bottom_next = head.y;
                            end
                            if (head.in_range)
                            begin
                                state_next = ST_ACCESS;
                            end
                        end
                        OP_READ:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                cmd_next = head;
                                if (head.in_range)
                                begin
                                    state_next = ST_ACCESS;
                                end
                                else
                                begin
                                    load_res = 1'b1;
                                end
                            end
                        end
                        OP_TAKE:
                        begin
                            if (out_free)
                            begin
                                pop      = 1'b1;
                                load_res = 1'b1;
                                if (dirty_valid_reg)
                                begin
                                    res.rect_valid = 1'b1;
                                    res.left       = dirty_left_reg;
                                    res.right      = dirty_right_reg;
                                    res.top        = dirty_top_reg;
                                    res.bottom     = dirty_bottom_reg;
                                end
                                dirty_valid_next  = 1'b0;
                                dirty_left_next   = EMPTY_LEFT;
                                dirty_right_next  = EMPTY_RIGHT;
                                dirty_top_next    = EMPTY_TOP;
                                dirty_bottom_next = EMPTY_BOTTOM;
                            end
                        end
                        OP_NONE:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.op == OP_DRAW)
                begin
                    we    = 1'b1;
                    wdata = cmd_reg.pix_on ? (rdata | mask) : (rdata & ~mask);
                end
                else
                begin
                    load_res     = 1'b1;
                    res.pixel_on = |(rdata & mask);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (load_res)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            dirty_valid_reg  <= 1'b0;
            dirty_left_reg   <= EMPTY_LEFT;
            dirty_right_reg  <= EMPTY_RIGHT;
            dirty_top_reg    <= EMPTY_TOP;
            dirty_bottom_reg <= EMPTY_BOTTOM;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            dirty_valid_reg  <= dirty_valid_next;
            dirty_left_reg   <= dirty_left_next;
            dirty_right_reg  <= dirty_right_next;
            dirty_top_reg    <= dirty_top_next;
            dirty_bottom_reg <= dirty_bottom_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> hdl/dithered_mono_page_framebuffer.sv
// Dithered monochrome page frame store.
// Input stream s_*: tuser carries the operation (draw, read, take rectangle),
// tdata the pixel position and colour. Operation code 3 is accepted and dropped.
// Output stream m_*: one result per read or take, none per draw.
// APB port: page stride at 0x0, tile_pattern at 0x4; pready is tied high.
// A front pipeline of two stages squares and weights the colour, picks the
// dither threshold and forms the byte address; a four-entry queue feeds the
// back end, which owns the byte store and the dirty rectangle.
// A read result passes the two front stages, the queue, the store read and
// the output register to m_tvalid; a take or a read outside the store skips
// the store read. Draws and reads in range use the back-end states IDLE (store
// read) and ACCESS (write or result) on the single read-modify-write path, and
// no command is popped in ACCESS; a take finishes in IDLE.
// Reset: the store is swept to zero, one byte a cycle, across all
// MAX_WIDTH*MAX_PAGES bytes (1024 by default); s_tready stays low meanwhile.
// A stalled m_tready holds the result; the next read or take then waits at the
// head of the queue, blocking everything behind it, and the front stops once
// the queue is full.
`default_nettype none

module dithered_mono_page_framebuffer
    import dmpf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pixel_x, pixel_y, red, green, blue, zero pad
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pixel_on, rect_valid, rect_left, rect_right,
                                        // rect_top, rect_bottom, zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       stride_sel;
    logic [7:0] page_stride_reg;
    logic [3:0] tile_pattern_reg;
    logic       cfg_write;
    logic       push;
    logic       full;
    logic       pop;
    logic       empty;
    logic       clearing;
    cmd_t       push_data;
    cmd_t       head;

    assign stride_sel = (paddr[2] == REG_PAGE_STRIDE);
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_PAGE_STRIDE:  prdata = {24'b0, page_stride_reg};
            REG_TILE_PATTERN: prdata = {28'b0, tile_pattern_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_stride_reg  <= PAGE_STRIDE_RESET;
            tile_pattern_reg <= TILE_PATTERN_RESET;
        end
        else if (cfg_write)
        begin
            if (stride_sel)
            begin
                page_stride_reg <= pwdata[7:0];
            end
            else
            begin
                tile_pattern_reg <= pwdata[3:0];
            end
        end
    end

    dmpf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold         (clearing),
        .page_stride  (page_stride_reg),
        .tile_pattern (tile_pattern_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    dmpf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    dmpf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/dmpf_checker.sv
`default_nettype none

module dmpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result carries both a pixel and a rectangle");

    a_empty_rect: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> (m_tdata[31:2] == 30'd0))
        else $error("empty rectangle fields not zero");

    a_rect_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |->
            (m_tdata[8:2] <= m_tdata[15:9]) && (m_tdata[21:16] <= m_tdata[27:22]))
        else $error("dirty rectangle bounds out of order");

endmodule

bind dithered_mono_page_framebuffer dmpf_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
